// File: rtl/ncm_pkg.sv
`timescale 1ns / 1ps
// ncm_pkg: shared types, constants and the oscillator table builder for the NCO mixer.
// No dependencies.
package ncm_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 13;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHR_W      = SUM_W - (SAMPLE_W - 1);

  localparam logic [63:0] Q61_ONE     = 64'h2000_0000_0000_0000;
  localparam logic [63:0] Q61_HALF_PI = 64'h3243_F6A8_885A_308D;

  // k*(k-1) for k = 25, 23, ..., 3
  localparam logic [63:0] SERIES_DIV [12] = '{
    64'd600, 64'd506, 64'd420, 64'd342, 64'd272, 64'd210,
    64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
  };

  typedef logic [TABLE_SIZE-1:0][2*SAMPLE_W-1:0] osc_rom_t;

  typedef struct packed {
    logic ld_in;
    logic ld_prod;
    logic ld_out;
  } pipe_en_t;

  function automatic logic [63:0] mul61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[124:61];
  endfunction

  // sin((pi/2) * r / TABLE_SIZE) in Q61
  function automatic logic [63:0] quarter_sin(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (Q61_HALF_PI / TABLE_SIZE) * r + ((Q61_HALF_PI % TABLE_SIZE) * r) / TABLE_SIZE;
    x2 = mul61(x, x);
    t  = Q61_ONE;
    for (int k = 0; k < 12; k++) begin
      t = Q61_ONE - mul61(x2, t) / SERIES_DIV[k];
    end
    return mul61(x, t);
  endfunction

  function automatic logic [SAMPLE_W-1:0] to_q15(input logic [63:0] s, input logic neg);
    logic [63:0] v;
    v = (s + 64'h0000_2000_0000_0000) >> 46;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return neg ? SAMPLE_W'(-v) : v[SAMPLE_W-1:0];
  endfunction

  // entry = {cos, sin}, each Q1.15
  function automatic osc_rom_t build_osc_rom();
    osc_rom_t    rom;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] sr;
    logic [63:0] sc;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      q  = (64'(4 * i)) / TABLE_SIZE;
      r  = (64'(4 * i)) % TABLE_SIZE;
      sr = quarter_sin(r);
      sc = quarter_sin(64'(TABLE_SIZE) - r);
      case (q[1:0])
        2'd0:    rom[i] = {to_q15(sc, 1'b0), to_q15(sr, 1'b0)};
        2'd1:    rom[i] = {to_q15(sr, 1'b1), to_q15(sc, 1'b0)};
        2'd2:    rom[i] = {to_q15(sc, 1'b1), to_q15(sr, 1'b1)};
        default: rom[i] = {to_q15(sr, 1'b0), to_q15(sc, 1'b1)};
      endcase
    end
    return rom;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SHR_W-1:0] v);
    if (v > SHR_W'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -SHR_W'(32768)) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// File: rtl/ncm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the NCO mixer: input item, result item, config write.
// Depends on ncm_pkg.
interface ncm_in_if
  import ncm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;
  logic                       block_end;
  modport source(output valid, sample_re, sample_im, block_end, input ready);
  modport sink(input valid, sample_re, sample_im, block_end, output ready);
endinterface

interface ncm_out_if
  import ncm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_re;
  logic signed [SAMPLE_W-1:0] mixed_im;
  logic                       block_end_out;
  modport source(output valid, mixed_re, mixed_im, block_end_out, input ready);
  modport sink(input valid, mixed_re, mixed_im, block_end_out, output ready);
endinterface

interface ncm_cfg_if
  import ncm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [STEP_W-1:0] shift_step;
  modport source(output valid, shift_step, input ready);
  modport sink(input valid, shift_step, output ready);
endinterface

// File: rtl/ncm_osc.sv
`timescale 1ns / 1ps
// ncm_osc: phase accumulator, shift step register and the cos/sin table ROM.
// Depends on ncm_pkg.
module ncm_osc
  import ncm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [STEP_W-1:0]          cfg_step,
  input  logic                       acc,
  output logic signed [SAMPLE_W-1:0] cos_q,
  output logic signed [SAMPLE_W-1:0] sin_q
);

  localparam osc_rom_t OSC_ROM = build_osc_rom();

  logic [IDX_W-1:0]      phase_r;
  logic [IDX_W-1:0]      phase_nxt;
  logic [STEP_W-1:0]     step_r;
  logic [2*SAMPLE_W-1:0] rom_q_r;

  // TABLE_SIZE is a power of two: index minus step modulo size
  assign phase_nxt = phase_r - step_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_step;
      end
      if (acc) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rom_q_r <= OSC_ROM[phase_r];
    end
  end

  assign cos_q = rom_q_r[2*SAMPLE_W-1:SAMPLE_W];
  assign sin_q = rom_q_r[SAMPLE_W-1:0];

endmodule

// File: rtl/ncm_cmul.sv
`timescale 1ns / 1ps
// ncm_cmul: pipelined complex multiply with Q15 rounding and saturation.
// Depends on ncm_pkg.
module ncm_cmul
  import ncm_pkg::*;
(
  input  logic                       clk,
  input  pipe_en_t                   en,
  input  logic signed [SAMPLE_W-1:0] a_re,
  input  logic signed [SAMPLE_W-1:0] a_im,
  input  logic                       be_in,
  input  logic signed [SAMPLE_W-1:0] cos_q,
  input  logic signed [SAMPLE_W-1:0] sin_q,
  output logic signed [SAMPLE_W-1:0] y_re,
  output logic signed [SAMPLE_W-1:0] y_im,
  output logic                       be_out
);

  logic signed [SAMPLE_W-1:0] re_r;
  logic signed [SAMPLE_W-1:0] im_r;
  logic                       be1_r;
  logic signed [PROD_W-1:0]   p_ac_r;
  logic signed [PROD_W-1:0]   p_bs_r;
  logic signed [PROD_W-1:0]   p_as_r;
  logic signed [PROD_W-1:0]   p_bc_r;
  logic                       be2_r;
  logic signed [SUM_W-1:0]    sum_re;
  logic signed [SUM_W-1:0]    sum_im;
  logic signed [SUM_W-1:0]    shr_re;
  logic signed [SUM_W-1:0]    shr_im;
  logic signed [SAMPLE_W-1:0] y_re_r;
  logic signed [SAMPLE_W-1:0] y_im_r;
  logic                       be3_r;

  always_ff @(posedge clk) begin
    if (en.ld_in) begin
      re_r  <= a_re;
      im_r  <= a_im;
      be1_r <= be_in;
    end
    if (en.ld_prod) begin
      p_ac_r <= re_r * cos_q;
      p_bs_r <= im_r * sin_q;
      p_as_r <= re_r * sin_q;
      p_bc_r <= im_r * cos_q;
      be2_r  <= be1_r;
    end
    if (en.ld_out) begin
      y_re_r <= sat16(shr_re[SHR_W-1:0]);
      y_im_r <= sat16(shr_im[SHR_W-1:0]);
      be3_r  <= be2_r;
    end
  end

  assign sum_re = SUM_W'(p_ac_r) - SUM_W'(p_bs_r) + SUM_W'(16384);
  assign sum_im = SUM_W'(p_as_r) + SUM_W'(p_bc_r) + SUM_W'(16384);
  assign shr_re = sum_re >>> (SAMPLE_W - 1);
  assign shr_im = sum_im >>> (SAMPLE_W - 1);

  assign y_re   = y_re_r;
  assign y_im   = y_im_r;
  assign be_out = be3_r;

endmodule

// File: rtl/nco_complex_mixer_top.sv
`timescale 1ns / 1ps
// nco_complex_mixer_top: NCO frequency shifter, valid/ready channels and pipeline control.
// Depends on ncm_pkg, ncm_if, ncm_osc, ncm_cmul.
//
// Usage:
//   in_ch  : complex sample (sample_re, sample_im) plus block_end flag, valid/ready.
//   out_ch : mixed sample (mixed_re, mixed_im) plus block_end_out, valid/ready.
//   cfg_ch : shift_step write; always ready, write only while the block is idle.
// Each accepted item is multiplied by the table entry (cos, sin) at the current
// phase index; the index then steps down by shift_step modulo the table size.
// The result passes the table read, product and round/saturate output registers.
// Throughput: one item per cycle while out_ch accepts results, one table read
// per item from the ROM port.
// Each pipeline stage has its own valid bit, so bubbles collapse and input
// is taken while a result waits in the output register; with the receiver
// stalled and all three stages full, in_ch.ready drops.
// Reset: phase index and shift_step clear to zero, pipeline empties.
// The cos/sin table is a fixed ROM; no fill pass is needed after reset.
module nco_complex_mixer_top
  import ncm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ncm_in_if.sink    in_ch,
  ncm_out_if.source out_ch,
  ncm_cfg_if.sink   cfg_ch
);

  logic                       s1_v_r;
  logic                       s2_v_r;
  logic                       out_v_r;
  logic                       en1;
  logic                       en2;
  logic                       en_out;
  logic                       acc;
  pipe_en_t                   pen;
  logic signed [SAMPLE_W-1:0] cos_q;
  logic signed [SAMPLE_W-1:0] sin_q;

  assign en_out = !out_v_r || out_ch.ready;
  assign en2    = !s2_v_r || en_out;
  assign en1    = !s1_v_r || en2;
  assign acc    = in_ch.valid && en1;

  assign in_ch.ready  = en1;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;

  assign pen.ld_in   = acc;
  assign pen.ld_prod = en2;
  assign pen.ld_out  = en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= acc;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  ncm_osc u_osc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_step (cfg_ch.shift_step),
    .acc      (acc),
    .cos_q    (cos_q),
    .sin_q    (sin_q)
  );

  ncm_cmul u_cmul (
    .clk    (clk),
    .en     (pen),
    .a_re   (in_ch.sample_re),
    .a_im   (in_ch.sample_im),
    .be_in  (in_ch.block_end),
    .cos_q  (cos_q),
    .sin_q  (sin_q),
    .y_re   (out_ch.mixed_re),
    .y_im   (out_ch.mixed_im),
    .be_out (out_ch.block_end_out)
  );

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !en1 |-> (s1_v_r && s2_v_r && out_v_r && !out_ch.ready))
    else $error("input blocked with a free pipeline slot");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_v_r)
    else $error("accepted item missing from first stage");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !en2) |=> s2_v_r)
    else $error("stalled product stage lost its item");

  a_out_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s2_v_r))
    else $error("result appeared without a product stage item");
`endif

endmodule
